>>> design/spq_pkg.sv
package spq_pkg;

    localparam int CAPACITY = 8;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // request opcodes
    localparam logic [1:0] OP_ENQUEUE = 2'd0;
    localparam logic [1:0] OP_DEQUEUE = 2'd1;
    localparam logic [1:0] OP_PEEK    = 2'd2;
    localparam logic [1:0] OP_LIST    = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // chain commands
    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_INSERT = 2'd1;
    localparam logic [1:0] CELL_REMOVE = 2'd2;
    localparam logic [1:0] CELL_ROTATE = 2'd3;

    typedef struct packed {
        logic               valid;
        logic signed [31:0] value;
        logic signed [31:0] prio;
    } t_entry;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] value;
        logic signed [31:0] prio;
    } t_cell_cmd;

endpackage

>>> design/spq_cell.sv
module spq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  spq_pkg::t_cell_cmd i_cmd,
    input  spq_pkg::t_entry    i_prev,
    input  logic               i_prev_gt,
    input  spq_pkg::t_entry    i_next,
    input  spq_pkg::t_entry    i_head,
    output spq_pkg::t_entry    o_entry,
    output logic               o_gt
);
    import spq_pkg::*;

    logic               r_valid;
    logic signed [31:0] r_value;
    logic signed [31:0] r_prio;
    t_entry             n_entry;

    // empty cells or larger priority numbers give way to the new entry
    assign o_gt    = !r_valid || (r_prio > i_cmd.prio);
    assign o_entry = '{valid: r_valid, value: r_value, prio: r_prio};

    always_comb begin
        n_entry = o_entry;
        case (i_cmd.op)
            CELL_HOLD: begin
                n_entry = o_entry;
            end
            CELL_INSERT: begin
                if (o_gt) begin
                    if (i_prev_gt) begin
                        n_entry = i_prev;
                    end else begin
                        n_entry = '{valid: 1'b1, value: i_cmd.value, prio: i_cmd.prio};
                    end
                end
            end
            CELL_REMOVE: begin
                n_entry = i_next;
            end
            CELL_ROTATE: begin
                if (r_valid) begin
                    // last occupied cell wraps around to the head
                    n_entry = i_next.valid ? i_next : i_head;
                end
            end
            default: begin
                n_entry = o_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_entry.value;
        r_prio  <= n_entry.prio;
    end

endmodule

>>> design/sorted_priority_queue.sv
// Sorted priority queue of CAPACITY entries held in a chain of cells, head in
// cell 0; a lower priority number leaves first and equal priorities leave in
// arrival order. A request is taken when i_start is high and o_busy is low.
// Enqueue, dequeue and peek each give a single registered result, shown on the
// cycle after the request with o_last set, and a new request may follow at
// once. A list request over n stored entries gives n results (one when the
// queue is empty): the chain rotates one place a cycle, the head is reported
// each cycle, and o_busy stays high until the final result is on the way.
// Every result is shown for exactly one cycle with o_valid high; the receiver
// cannot stall, so it must take each result in the cycle it appears.
module sorted_priority_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [1:0]         i_opcode,
    input  logic signed [31:0] i_value,
    input  logic signed [31:0] i_priority_req,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_out_value,
    output logic signed [31:0] o_out_priority,
    output logic               o_last
);
    import spq_pkg::*;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

    // occupancy and list walk control
    logic [CNT_W-1:0] r_count,  n_count;
    logic [CNT_W-1:0] r_remain, n_remain;

    // registered result
    logic               r_valid,  n_valid;
    logic [1:0]         r_status, n_status;
    logic signed [31:0] r_value,  n_value;
    logic signed [31:0] r_prio,   n_prio;
    logic               r_last,   n_last;

    t_cell_cmd w_cmd;
    t_entry    w_ent [CAPACITY];
    logic      w_gt  [CAPACITY];
    logic      w_accept;

    assign o_busy   = (r_remain != '0);
    assign w_accept = i_start && !o_busy;

    // chain of cells, each one talking to its neighbors and to the head cell
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            t_entry w_prev;
            t_entry w_next;
            logic   w_prev_gt;

            if (g == 0) begin : g_first
                assign w_prev    = '0;
                assign w_prev_gt = 1'b0;
            end else begin : g_mid
                assign w_prev    = w_ent[g-1];
                assign w_prev_gt = w_gt[g-1];
            end

            if (g == CAPACITY - 1) begin : g_tail
                assign w_next = '0;
            end else begin : g_body
                assign w_next = w_ent[g+1];
            end

            spq_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_cmd     (w_cmd),
                .i_prev    (w_prev),
                .i_prev_gt (w_prev_gt),
                .i_next    (w_next),
                .i_head    (w_ent[0]),
                .o_entry   (w_ent[g]),
                .o_gt      (w_gt[g])
            );
        end
    endgenerate

    // request decode
    always_comb begin
        w_cmd    = '{op: CELL_HOLD, value: i_value, prio: i_priority_req};
        n_count  = r_count;
        n_remain = r_remain;
        n_valid  = 1'b0;
        n_status = ST_OK;
        n_value  = w_ent[0].value;
        n_prio   = w_ent[0].prio;
        n_last   = 1'b1;

        if (o_busy) begin
            // list walk in progress: report head, rotate
            n_valid  = 1'b1;
            n_last   = (r_remain == ONE_CNT);
            n_remain = r_remain - ONE_CNT;
            w_cmd.op = CELL_ROTATE;
        end else if (w_accept) begin
            n_valid = 1'b1;
            case (i_opcode)
                OP_ENQUEUE: begin
                    if (r_count == CAP_CNT) begin
                        n_status = ST_FULL;
                        n_value  = '0;
                        n_prio   = '0;
                    end else begin
                        n_value  = i_value;
                        n_prio   = i_priority_req;
                        w_cmd.op = CELL_INSERT;
                        n_count  = r_count + ONE_CNT;
                    end
                end
                OP_DEQUEUE, OP_PEEK: begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                        n_value  = '0;
                        n_prio   = '0;
                    end else if (i_opcode == OP_DEQUEUE) begin
                        w_cmd.op = CELL_REMOVE;
                        n_count  = r_count - ONE_CNT;
                    end
                end
                OP_LIST: begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                        n_value  = '0;
                        n_prio   = '0;
                    end else begin
                        // first entry goes out now, the rest follow
                        n_last   = (r_count == ONE_CNT);
                        n_remain = r_count - ONE_CNT;
                        w_cmd.op = CELL_ROTATE;
                    end
                end
                default: begin
                    n_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_remain <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_remain <= n_remain;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_value  <= n_value;
        r_prio   <= n_prio;
        r_last   <= n_last;
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_out_value    = r_value;
    assign o_out_priority = r_prio;
    assign o_last         = r_last;

endmodule

>>> tb/sv/testbench.sv
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    // cycles with neither a request taken nor a result shown before giving up
    localparam int unsigned STALL_LIMIT = 400;
    // quiet cycles after the last awaited result, to catch stray strobes
    localparam int unsigned TAIL_CYCLES = 20;

    // one request plus how the driver should pace it
    typedef struct {
        logic [1:0]         op;
        logic signed [31:0] value;
        logic signed [31:0] prio;
        int unsigned        idle_before;   // start-low cycles before presenting it
        bit                 wait_drained;  // hold off until every result is back
    } t_request;

    typedef struct {
        logic [1:0]         status;
        logic signed [31:0] value;
        logic signed [31:0] prio;
        logic               last;
    } t_result;

    logic               i_clk;
    logic               i_rst_n        = 1'b0;
    logic               i_start        = 1'b0;
    logic [1:0]         i_opcode       = OP_ENQUEUE;
    logic signed [31:0] i_value        = '0;
    logic signed [31:0] i_priority_req = '0;
    logic               o_busy;
    logic               o_valid;
    logic [1:0]         o_status;
    logic signed [31:0] o_out_value;
    logic signed [31:0] o_out_priority;
    logic               o_last;

    sorted_priority_queue DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_opcode       (i_opcode),
        .i_value        (i_value),
        .i_priority_req (i_priority_req),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_out_value    (o_out_value),
        .o_out_priority (o_out_priority),
        .o_last         (o_last)
    );

    // requests still to send, results still to arrive
    t_request pending_requests[$];
    t_result  awaited_results[$];

    // shadow copy of the queue contents, head at index 0
    logic signed [31:0] shadow_value[CAPACITY];
    logic signed [31:0] shadow_prio[CAPACITY];
    int unsigned        shadow_count = 0;

    // driver pacing
    bit          front_loaded = 1'b0;
    int unsigned idle_left    = 0;

    // bookkeeping for the summary
    int unsigned ops_sent[4];
    int unsigned status_seen[4];
    int unsigned results_seen = 0;
    int unsigned error_count  = 0;
    int unsigned stall_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_result make_result(logic [1:0] st, logic signed [31:0] v,
                                            logic signed [31:0] p, logic lst);
        t_result r;
        r.status = st;
        r.value  = v;
        r.prio   = p;
        r.last   = lst;
        return r;
    endfunction

    // apply one request to the shadow queue and queue up the results it causes
    task automatic apply_to_shadow_queue(input t_request req);
        int pos;
        case (req.op)
            OP_ENQUEUE: begin
                if (shadow_count >= CAPACITY) begin
                    awaited_results.push_back(make_result(ST_FULL, '0, '0, 1'b1));
                end else begin
                    // slide later entries back; equal priorities stay ahead
                    pos = shadow_count;
                    while (pos > 0 && shadow_prio[pos-1] > req.prio) begin
                        shadow_value[pos] = shadow_value[pos-1];
                        shadow_prio[pos]  = shadow_prio[pos-1];
                        pos--;
                    end
                    shadow_value[pos] = req.value;
                    shadow_prio[pos]  = req.prio;
                    shadow_count++;
                    awaited_results.push_back(make_result(ST_OK, req.value, req.prio, 1'b1));
                end
            end
            OP_DEQUEUE, OP_PEEK: begin
                if (shadow_count == 0) begin
                    awaited_results.push_back(make_result(ST_EMPTY, '0, '0, 1'b1));
                end else begin
                    awaited_results.push_back(
                        make_result(ST_OK, shadow_value[0], shadow_prio[0], 1'b1));
                    if (req.op == OP_DEQUEUE) begin
                        for (pos = 0; pos + 1 < shadow_count; pos++) begin
                            shadow_value[pos] = shadow_value[pos+1];
                            shadow_prio[pos]  = shadow_prio[pos+1];
                        end
                        shadow_count--;
                    end
                end
            end
            default: begin
                // list: every entry head to tail, last flag on the tail only
                if (shadow_count == 0) begin
                    awaited_results.push_back(make_result(ST_EMPTY, '0, '0, 1'b1));
                end else begin
                    for (pos = 0; pos < shadow_count; pos++) begin
                        awaited_results.push_back(make_result(ST_OK, shadow_value[pos],
                            shadow_prio[pos], logic'(pos + 1 == shadow_count)));
                    end
                end
            end
        endcase
    endtask

    task automatic queue_request(input logic [1:0] op, input logic signed [31:0] v,
                                 input logic signed [31:0] p, input int unsigned idle,
                                 input bit drained);
        t_request req;
        req.op           = op;
        req.value        = v;
        req.prio         = p;
        req.idle_before  = idle;
        req.wait_drained = drained;
        pending_requests.push_back(req);
    endtask

    // driver: present the front request, hold it until taken, then pace the next
    always @(posedge i_clk) begin
        logic start_next;
        start_next = i_start;
        if (!i_rst_n) begin
            start_next = 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                // request taken at this edge
                apply_to_shadow_queue(pending_requests[0]);
                ops_sent[pending_requests[0].op]++;
                void'(pending_requests.pop_front());
                front_loaded = 1'b0;
                start_next   = 1'b0;
            end
            if (!start_next && pending_requests.size() > 0) begin
                if (!front_loaded) begin
                    idle_left    = pending_requests[0].idle_before;
                    front_loaded = 1'b1;
                end
                if (idle_left > 0) begin
                    idle_left--;
                end else if (!(pending_requests[0].wait_drained &&
                               awaited_results.size() > 0)) begin
                    start_next = 1'b1;
                end
            end
        end
        if (start_next) begin
            i_opcode       <= pending_requests[0].op;
            i_value        <= pending_requests[0].value;
            i_priority_req <= pending_requests[0].prio;
        end else begin
            // junk on the payload while start is low
            i_opcode       <= 2'($urandom_range(0, 3));
            i_value        <= $urandom;
            i_priority_req <= $urandom;
        end
        i_start <= start_next;
    end

    // monitor: every strobed result against the oldest awaited one
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if ($isunknown(o_valid) || $isunknown(o_busy)) begin
                $error("unknown handshake: o_valid=%b o_busy=%b", o_valid, o_busy);
                error_count++;
            end
            if (o_valid === 1'b1) begin
                results_seen++;
                status_seen[o_status]++;
                if (awaited_results.size() == 0) begin
                    $error("result with nothing awaited: status=%0d value=%0d prio=%0d",
                           o_status, o_out_value, o_out_priority);
                    error_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        error_count++;
                    end
                    if (o_out_value !== want.value) begin
                        $error("out_value: expected %0d, got %0d", want.value, o_out_value);
                        error_count++;
                    end
                    if (o_out_priority !== want.prio) begin
                        $error("out_priority: expected %0d, got %0d",
                               want.prio, o_out_priority);
                        error_count++;
                    end
                    if (o_last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, o_last);
                        error_count++;
                    end
                end
            end
        end
    end

    // watchdog: nothing moving for too long means a hang or lost results
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: %0d idle cycles, %0d requests unsent, %0d results missing",
                     stall_cycles, pending_requests.size(), awaited_results.size());
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int unsigned mode;
        int unsigned pick;
        int unsigned idle;
        bit          quiet;
        logic [1:0]         op;
        logic signed [31:0] prio;

        // empty queue: dequeue, peek and list all report empty
        queue_request(OP_DEQUEUE, 32'sd11, 32'sd3, 0, 1'b0);
        queue_request(OP_PEEK,    32'sd12, 32'sd4, 0, 1'b0);
        queue_request(OP_LIST,    32'sd13, 32'sd5, 0, 1'b0);
        // fill with extreme values and priorities, including a tie
        queue_request(OP_ENQUEUE, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 1'b0);
        queue_request(OP_ENQUEUE, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 1'b0);
        queue_request(OP_ENQUEUE, 32'sd0,         32'sd0,         0, 1'b0);
        queue_request(OP_ENQUEUE, -32'sd1,        -32'sd1,        0, 1'b0);
        queue_request(OP_ENQUEUE, 32'sd5,         32'sd0,         0, 1'b0);
        queue_request(OP_ENQUEUE, 32'sd6,         32'sd0,         0, 1'b0);
        queue_request(OP_ENQUEUE, 32'shAAAA_AAAA, 32'sh5555_5555, 0, 1'b0);
        queue_request(OP_ENQUEUE, 32'sh5555_5555, 32'shAAAA_AAAA, 0, 1'b0);
        // full: overflow is refused and nothing moves
        queue_request(OP_ENQUEUE, 32'sd1, 32'sd1, 0, 1'b0);
        // sender waits for everything outstanding before the full list
        queue_request(OP_LIST, 32'sd0, 32'sd0, 0, 1'b1);
        queue_request(OP_PEEK, 32'sd0, 32'sd0, 0, 1'b0);
        queue_request(OP_DEQUEUE, 32'sd0, 32'sd0, 0, 1'b0);
        queue_request(OP_DEQUEUE, 32'sd0, 32'sd0, 0, 1'b0);
        // tie against an entry already stored
        queue_request(OP_ENQUEUE, 32'sd9, -32'sd1, 0, 1'b0);
        queue_request(OP_LIST, 32'sd0, 32'sd0, 0, 1'b0);
        repeat (4) queue_request(OP_DEQUEUE, 32'sd0, 32'sd0, 2, 1'b0);
        queue_request(OP_LIST, 32'sd0, 32'sd0, 0, 1'b0);

        // random part in segments that lean toward filling or emptying
        for (int seg = 0; seg < 10; seg++) begin
            mode  = $urandom_range(0, 2);
            quiet = ($urandom_range(0, 2) == 0) || (seg >= 8);
            for (int k = 0; k < 20; k++) begin
                pick = $urandom_range(0, 99);
                case (mode)
                    0:       op = (pick < 70) ? OP_ENQUEUE : (pick < 80) ? OP_DEQUEUE :
                                  (pick < 90) ? OP_PEEK : OP_LIST;
                    1:       op = (pick < 20) ? OP_ENQUEUE : (pick < 75) ? OP_DEQUEUE :
                                  (pick < 85) ? OP_PEEK : OP_LIST;
                    default: op = (pick < 40) ? OP_ENQUEUE : (pick < 70) ? OP_DEQUEUE :
                                  (pick < 85) ? OP_PEEK : OP_LIST;
                endcase
                // mostly narrow priorities so ties are common
                case ($urandom_range(0, 3))
                    0, 1:    prio = $signed(32'($urandom_range(0, 6))) - 32'sd3;
                    2:       prio = $urandom;
                    default: begin
                        case ($urandom_range(0, 3))
                            0:       prio = 32'sh8000_0000;
                            1:       prio = 32'sh7FFF_FFFF;
                            2:       prio = 32'sd0;
                            default: prio = -32'sd1;
                        endcase
                    end
                endcase
                idle = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
                queue_request(op, $urandom, prio, idle,
                              !quiet && ($urandom_range(0, 39) == 0));
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_requests.size() > 0 || awaited_results.size() > 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("requests sent: %0d enqueue, %0d dequeue, %0d peek, %0d list",
                 ops_sent[OP_ENQUEUE], ops_sent[OP_DEQUEUE], ops_sent[OP_PEEK],
                 ops_sent[OP_LIST]);
        $display("results checked: %0d (%0d refused as full, %0d empty), %0d errors",
                 results_seen, status_seen[ST_FULL], status_seen[ST_EMPTY], error_count);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> files.f
design/spq_pkg.sv
design/spq_cell.sv
design/sorted_priority_queue.sv
tb/sv/testbench.sv
